// ===== sv/left_to_right_calculator_top_defines.svh =====
// assertion macros shared by the calculator rtl
`ifndef LEFT_TO_RIGHT_CALCULATOR_TOP_DEFINES_SVH
`define LEFT_TO_RIGHT_CALCULATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define LTRC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltrc assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define LTRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltrc assertion failed");
`else
`define LTRC_ASSERT_IMPL(label, ante, cons)
`define LTRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/ltrc_pkg.sv =====
// shared constants, codes and command type of the calculator
`timescale 1ns / 1ps

package ltrc_pkg;

    // default sizes
    localparam int WORD_BITS_DEF     = 48;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // decimal digits
    localparam int DIGIT_BITS = 4;
    localparam logic [DIGIT_BITS-1:0] DECIMAL_BASE = 4'd10;

    // ascii characters that act
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_DIGIT = 2'd0;
    localparam logic [1:0] CMD_OPER  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // one classified character: digit value or operator code in arg
    typedef struct packed {
        logic [1:0]            kind;
        logic [DIGIT_BITS-1:0] arg;
    } ltrc_cmd_t;

endpackage

// ===== sv/ltrc_if.sv =====
// valid/ready channel interfaces for expression characters and results
`timescale 1ns / 1ps

interface ltrc_expr_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expression;

    modport source (output valid, symbol, end_of_expression, input ready);
    modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

interface ltrc_result_if #(
    parameter int WORD_BITS = ltrc_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] result_value;
    logic                        divided_by_zero;
    logic                        saturated;

    modport source (output valid, result_value, divided_by_zero, saturated, input ready);
    modport sink   (input valid, result_value, divided_by_zero, saturated, output ready);
endinterface

// ===== sv/ltrc_front.sv =====
// front end: takes characters and classifies them into commands
`timescale 1ns / 1ps

module ltrc_front (
    ltrc_expr_if.sink        expr,
    output logic             push_valid,
    output ltrc_pkg::ltrc_cmd_t push_cmd,
    input  logic             push_ready
);
    import ltrc_pkg::*;

    logic [7:0] digit_full;
    logic       is_digit;
    logic       is_oper;
    logic [1:0] oper_code;

    // a character is taken whenever the queue has room
    assign expr.ready = push_ready;

    // character classes
    assign digit_full = expr.symbol - CHAR_ZERO;
    assign is_digit   = (expr.symbol >= CHAR_ZERO) && (expr.symbol <= CHAR_NINE);
    assign is_oper    = (expr.symbol == CHAR_PLUS) || (expr.symbol == CHAR_MINUS) ||
                        (expr.symbol == CHAR_STAR) || (expr.symbol == CHAR_SLASH);

    // operator code
    always_comb
    begin
        priority if (expr.symbol == CHAR_PLUS)
        begin
            oper_code = OP_ADD;
        end
        else if (expr.symbol == CHAR_MINUS)
        begin
            oper_code = OP_SUB;
        end
        else if (expr.symbol == CHAR_STAR)
        begin
            oper_code = OP_MUL;
        end
        else
        begin
            oper_code = OP_DIV;
        end
    end

    // build the command, ignored characters are dropped here
    always_comb
    begin
        push_cmd.kind = CMD_DIGIT;
        push_cmd.arg  = digit_full[DIGIT_BITS-1:0];
        push_valid    = 1'b0;
        priority if (expr.end_of_expression)
        begin
            push_cmd.kind = CMD_END;
            push_valid    = expr.valid;
        end
        else if (is_digit)
        begin
            push_valid = expr.valid;
        end
        else if (is_oper)
        begin
            push_cmd.kind = CMD_OPER;
            push_cmd.arg  = {{(DIGIT_BITS-2){1'b0}}, oper_code};
            push_valid    = expr.valid;
        end
        else
        begin
            push_valid = 1'b0;
        end
    end

endmodule

// ===== sv/ltrc_queue.sv =====
// command queue between front end and execution back end
`timescale 1ns / 1ps

`include "left_to_right_calculator_top_defines.svh"

module ltrc_queue #(
    parameter int DEPTH = ltrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ltrc_pkg::ltrc_cmd_t push_cmd,
    output logic                push_ready,
    output logic                pop_valid,
    output ltrc_pkg::ltrc_cmd_t pop_cmd,
    input  logic                pop_ready
);
    import ltrc_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    ltrc_cmd_t           slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill count follows the transfers
    `LTRC_ASSERT_NEXT(a_q_push_count, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1)
    `LTRC_ASSERT_NEXT(a_q_pop_count, pop_fire && !push_fire, count_reg == $past(count_reg) - 1'b1)
    // an empty queue has both pointers on the same slot
    `LTRC_ASSERT_IMPL(a_q_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== sv/ltrc_back.sv =====
// back end: digit entry, add/sub, bit-serial multiply and divide, result register
`timescale 1ns / 1ps

`include "left_to_right_calculator_top_defines.svh"

module ltrc_back #(
    parameter int WORD_BITS     = ltrc_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = ltrc_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ltrc_pkg::ltrc_cmd_t cmd,
    output logic                cmd_ready,
    ltrc_result_if.source       result
);
    import ltrc_pkg::*;

    localparam int W         = WORD_BITS;
    localparam int F         = FRACTION_BITS;
    localparam int NUM_BITS  = W + F;
    localparam int PROD_BITS = 2 * W;
    localparam int MAG_BITS  = ((2 * W - F) > (W + F)) ? (2 * W - F) : (W + F);
    localparam int DIG_BITS  = ((W > F + DIGIT_BITS) ? W : F + DIGIT_BITS) + 5;
    localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

    localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    // state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // control and expression state
    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        opd_reg, opd_next;
    logic [1:0]          pend_reg, pend_next;
    logic                zdiv_reg, zdiv_next;
    logic                sat_reg, sat_next;
    logic                out_valid_reg, out_valid_next;

    // working and payload registers
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic [NUM_BITS-1:0]  num_reg, num_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         bmag_reg, bmag_next;
    logic                 neg_reg, neg_next;
    logic                 end_reg, end_next;
    logic [1:0]           nop_reg, nop_next;
    logic [W-1:0]         out_value_reg, out_value_next;
    logic                 out_zdiv_reg, out_zdiv_next;
    logic                 out_sat_reg, out_sat_next;

    logic                slot_free;
    logic                cmd_fire;
    logic                out_load;
    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [DIG_BITS-1:0] dig_sum;
    logic                dig_sat;
    logic [W:0]          as_sum;
    logic                as_ovf;
    logic [W-1:0]        as_res;
    logic [W:0]          mul_add;
    logic [W:0]          rem_sh;
    logic                rem_ge;
    logic [MAG_BITS-1:0] wide_mag;
    logic [W-1:0]        wide_low;
    logic                wide_ovf;
    logic [W-1:0]        wide_res;
    logic                do_finish;
    logic                fin_end;
    logic [1:0]          fin_op;
    logic [W-1:0]        fin_res;
    logic                fin_sat;
    logic                fin_zdiv;

    // handshakes
    assign slot_free = !out_valid_reg || result.ready;
    assign cmd_ready = (state_reg == ST_IDLE) && ((cmd.kind != CMD_END) || slot_free);
    assign cmd_fire  = cmd_valid && cmd_ready;

    // operand magnitudes
    assign mag_a = acc_reg[W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign mag_b = opd_reg[W-1] ? (~opd_reg + 1'b1) : opd_reg;

    // decimal digit append: operand * 10 + digit, clamped at the top
    assign dig_sum = (DIG_BITS'(opd_reg) * DIG_BITS'(DECIMAL_BASE)) +
                     (DIG_BITS'(cmd.arg) << F);
    assign dig_sat = dig_sum > DIG_BITS'(VAL_MAX);

    // add or subtract with overflow clamp
    assign as_sum = (pend_reg == OP_SUB) ? ({acc_reg[W-1], acc_reg} - {opd_reg[W-1], opd_reg})
                                         : ({acc_reg[W-1], acc_reg} + {opd_reg[W-1], opd_reg});
    assign as_ovf = as_sum[W] ^ as_sum[W-1];
    assign as_res = as_ovf ? (as_sum[W] ? VAL_MIN : VAL_MAX) : as_sum[W-1:0];

    // one shift-add step of the multiplier
    assign mul_add = {1'b0, prod_reg[PROD_BITS-1:W]} + (prod_reg[0] ? {1'b0, bmag_reg} : '0);

    // one restoring step of the divider
    assign rem_sh = {rem_reg, num_reg[NUM_BITS-1]};
    assign rem_ge = rem_sh >= {1'b0, bmag_reg};

    // rescale and clamp a finished product or quotient magnitude
    always_comb
    begin
        if (pend_reg == OP_DIV)
        begin
            wide_mag = MAG_BITS'(num_reg);
        end
        else
        begin
            wide_mag = MAG_BITS'(prod_reg >> F);
        end
        wide_low = wide_mag[W-1:0];
        wide_ovf = (|wide_mag[MAG_BITS-1:W]) || (wide_low > (neg_reg ? VAL_MIN : VAL_MAX));
        if (wide_ovf)
        begin
            wide_res = neg_reg ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            wide_res = neg_reg ? (~wide_low + 1'b1) : wide_low;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        opd_next       = opd_reg;
        pend_next      = pend_reg;
        zdiv_next      = zdiv_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        bmag_next      = bmag_reg;
        neg_next       = neg_reg;
        end_next       = end_reg;
        nop_next       = nop_reg;
        out_value_next = out_value_reg;
        out_zdiv_next  = out_zdiv_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_load       = 1'b0;
        do_finish      = 1'b0;
        fin_end        = end_reg;
        fin_op         = nop_reg;
        fin_res        = '0;
        fin_sat        = 1'b0;
        fin_zdiv       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    fin_end  = (cmd.kind == CMD_END);
                    fin_op   = cmd.arg[1:0];
                    end_next = (cmd.kind == CMD_END);
                    nop_next = cmd.arg[1:0];
                    neg_next = acc_reg[W-1] ^ opd_reg[W-1];
                    unique case (cmd.kind)
                        CMD_DIGIT:
                        begin
                            opd_next = dig_sat ? VAL_MAX : dig_sum[W-1:0];
                            sat_next = sat_reg || dig_sat;
                        end
                        CMD_OPER, CMD_END:
                        begin
                            unique case (pend_reg)
                                OP_ADD, OP_SUB:
                                begin
                                    do_finish = 1'b1;
                                    fin_res   = as_res;
                                    fin_sat   = as_ovf;
                                end
                                OP_MUL:
                                begin
                                    prod_next  = {{W{1'b0}}, mag_b};
                                    bmag_next  = mag_a;
                                    cnt_next   = '0;
                                    state_next = ST_MUL;
                                end
                                OP_DIV:
                                begin
                                    if (opd_reg == '0)
                                    begin
                                        do_finish = 1'b1;
                                        fin_res   = '0;
                                        fin_zdiv  = 1'b1;
                                    end
                                    else
                                    begin
                                        num_next   = NUM_BITS'(mag_a) << F;
                                        rem_next   = '0;
                                        bmag_next  = mag_b;
                                        cnt_next   = '0;
                                        state_next = ST_DIV;
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_add, prod_reg[W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? W'(rem_sh - {1'b0, bmag_reg}) : rem_sh[W-1:0];
                num_next = {num_reg[NUM_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(NUM_BITS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!end_reg || slot_free)
                begin
                    do_finish  = 1'b1;
                    fin_res    = wide_res;
                    fin_sat    = wide_ovf;
                    state_next = ST_IDLE;
                end
            end
        endcase

        // retire an operation: either close the expression or chain on
        if (do_finish)
        begin
            if (fin_end)
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                out_value_next = fin_res;
                out_zdiv_next  = zdiv_reg || fin_zdiv;
                out_sat_next   = sat_reg || fin_sat;
                acc_next       = '0;
                opd_next       = '0;
                pend_next      = OP_ADD;
                zdiv_next      = 1'b0;
                sat_next       = 1'b0;
            end
            else
            begin
                acc_next  = fin_res;
                opd_next  = '0;
                pend_next = fin_op;
                zdiv_next = zdiv_reg || fin_zdiv;
                sat_next  = sat_reg || fin_sat;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            opd_reg       <= '0;
            pend_reg      <= OP_ADD;
            zdiv_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            opd_reg       <= opd_next;
            pend_reg      <= pend_next;
            zdiv_reg      <= zdiv_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        bmag_reg      <= bmag_next;
        neg_reg       <= neg_next;
        end_reg       <= end_next;
        nop_reg       <= nop_next;
        out_value_reg <= out_value_next;
        out_zdiv_reg  <= out_zdiv_next;
        out_sat_reg   <= out_sat_next;
    end

    // result channel
    assign result.valid           = out_valid_reg;
    assign result.result_value    = $signed(out_value_reg);
    assign result.divided_by_zero = out_zdiv_reg;
    assign result.saturated       = out_sat_reg;

    // commands are taken only between operations
    `LTRC_ASSERT_IMPL(a_pop_idle, cmd_fire, state_reg == ST_IDLE)
    // a result is never loaded over one that is still waiting
    `LTRC_ASSERT_IMPL(a_load_free, out_load, slot_free)
    // closing an expression leaves the reset state behind
    `LTRC_ASSERT_NEXT(a_end_clear, out_load, acc_reg == '0 && opd_reg == '0 && pend_reg == OP_ADD)
    // multiply count stays within the word
    `LTRC_ASSERT_IMPL(a_mul_count, state_reg == ST_MUL, cnt_reg < CNT_BITS'(W))

endmodule

// ===== sv/left_to_right_calculator_top.sv =====
// top level of the left-to-right four-function calculator
//
//  channel | dir  | payload                                        | transfer when
//  expr    | in   | symbol[7:0], end_of_expression                 | valid && ready
//  result  | out  | result_value[WORD_BITS-1:0], divided_by_zero,  | valid && ready
//          |      | saturated                                      |
//
// a character is taken whenever the command queue has room
// ignored characters are dropped at the front; in the back end a digit, add, subtract
// or zero divisor is handled from the idle state, while multiply runs the bit-serial
// shift-add loop and divide the restoring divide loop, each followed by a finish state
// asynchronous active-low reset clears the expression state, queue and result valid flag
// an end marker waits in the back end until the result register is free
`timescale 1ns / 1ps

module left_to_right_calculator_top #(
    parameter int WORD_BITS     = ltrc_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = ltrc_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = ltrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ltrc_expr_if.sink     expr,
    ltrc_result_if.source result
);
    import ltrc_pkg::*;

    logic      push_valid;
    logic      push_ready;
    ltrc_cmd_t push_cmd;
    logic      pop_valid;
    logic      pop_ready;
    ltrc_cmd_t pop_cmd;

    // classify characters
    ltrc_front u_front (
        .expr       (expr),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // decouple front and back
    ltrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // evaluate
    ltrc_back #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .result    (result)
    );

endmodule
